>>> rtl/two_tail_frame_deframer_macros.svh
// ----------------------------------------------------------------------------
// Two-tail frame deframer assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef TWO_TAIL_FRAME_DEFRAMER_MACROS_SVH
`define TWO_TAIL_FRAME_DEFRAMER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define TTFD_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset.
`define TTFD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/ttfd_pkg.sv
// ----------------------------------------------------------------------------
// Two-tail frame deframer package
// Frame byte codes and the types passed between the deframer stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ttfd_pkg;

   localparam logic [7:0] HDR_FIRST   = 8'hAA;
   localparam logic [7:0] HDR_SECOND  = 8'hBB;
   localparam logic [7:0] TAIL0_FIRST = 8'hCC;
   localparam logic [7:0] TAIL0_LAST  = 8'hDD;
   localparam logic [7:0] TAIL1_FIRST = 8'hEE;
   localparam logic [7:0] TAIL1_LAST  = 8'hFF;

   localparam logic KIND_TAIL0 = 1'b0;
   localparam logic KIND_TAIL1 = 1'b1;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
   } byte_slot_type;

   typedef struct packed {
      logic        valid;
      logic        frame_kind;
      logic [15:0] distance_raw;
      logic [15:0] length_raw;
   } result_type;

endpackage

`default_nettype wire

>>> rtl/two_tail_frame_deframer.sv
// ----------------------------------------------------------------------------
// Two-tail frame deframer
// Byte stream frame sync parser for AA BB framed records with two tail kinds.
// ----------------------------------------------------------------------------
// One byte is taken per transaction on req_ and the parser hunts for 8-byte
// frames: AA BB, distance (2 bytes, big-endian), length (2 bytes, big-endian),
// then tail CC DD (kind 0) or EE FF (kind 1). A bad header or tail byte drops
// the partial frame; an AA there restarts the header. Each complete frame gives
// one rsp_ transaction with the kind and the raw counts in hundredths. Bytes
// are taken one per cycle, set by the single-step parser state machine, except
// while a finished result waits under rsp_stall; the last tail byte passes the
// input byte register and then the result register before rsp_valid rises.
`timescale 1ns / 1ps
`default_nettype none

module two_tail_frame_deframer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_frame_kind,
   output logic [15:0]      rsp_distance_raw,
   output logic [15:0]      rsp_length_raw
);

   ttfd_pkg::byte_slot_type slot;
   ttfd_pkg::result_type    result;
   logic                    advance;

   ttfd_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_rx_byte (req_rx_byte),
      .advance     (advance),
      .req_stall   (req_stall),
      .slot        (slot)
   );

   ttfd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .slot    (slot),
      .result  (result)
   );

   ttfd_out_stage u_out_stage (
      .clock            (clock),
      .reset            (reset),
      .result           (result),
      .rsp_stall        (rsp_stall),
      .advance          (advance),
      .rsp_valid        (rsp_valid),
      .rsp_frame_kind   (rsp_frame_kind),
      .rsp_distance_raw (rsp_distance_raw),
      .rsp_length_raw   (rsp_length_raw)
   );

endmodule

`default_nettype wire

>>> rtl/ttfd_in_stage.sv
// ----------------------------------------------------------------------------
// Two-tail frame deframer input stage
// Registers one received byte and holds it until the parser advances.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ttfd_in_stage (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic [7:0]             req_rx_byte,
   input  wire logic                   advance,
   output logic                        req_stall,
   output ttfd_pkg::byte_slot_type     slot
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] data_ff;
   logic       take;

   assign req_stall = valid_ff && !advance;
   assign take      = req_valid && !req_stall;
   assign valid_in  = take || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         data_ff <= req_rx_byte;
      end
   end

   assign slot.valid = valid_ff;
   assign slot.data  = data_ff;

endmodule

`default_nettype wire

>>> rtl/ttfd_parser.sv
// ----------------------------------------------------------------------------
// Two-tail frame deframer parser
// Frame sync state machine with distance and length assembly.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ttfd_parser (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  wire ttfd_pkg::byte_slot_type slot,
   output ttfd_pkg::result_type        result
);

   typedef enum logic [3:0] {
      PH_HUNT,
      PH_HDR,
      PH_DIST_HI,
      PH_DIST_LO,
      PH_LEN_HI,
      PH_LEN_LO,
      PH_TAIL,
      PH_TAIL0,
      PH_TAIL1
   } phase_type;

   phase_type   phase_ff;
   phase_type   phase_in;
   logic [15:0] distance_ff;
   logic [15:0] distance_in;
   logic [15:0] length_ff;
   logic [15:0] length_in;
   logic        emit;
   logic        kind;
   phase_type   resync;
   logic [7:0]  b;

   assign b      = slot.data;
   assign resync = (b == ttfd_pkg::HDR_FIRST) ? PH_HDR : PH_HUNT;

   always_comb begin
      phase_in    = phase_ff;
      distance_in = distance_ff;
      length_in   = length_ff;
      emit        = 1'b0;
      kind        = ttfd_pkg::KIND_TAIL0;
      unique case (phase_ff)
         PH_HUNT: begin
            phase_in = resync;
         end
         PH_HDR: begin
            phase_in = (b == ttfd_pkg::HDR_SECOND) ? PH_DIST_HI : resync;
         end
         PH_DIST_HI: begin
            distance_in = {distance_ff[7:0], b};
            phase_in    = PH_DIST_LO;
         end
         PH_DIST_LO: begin
            distance_in = {distance_ff[7:0], b};
            phase_in    = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            length_in = {length_ff[7:0], b};
            phase_in  = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            length_in = {length_ff[7:0], b};
            phase_in  = PH_TAIL;
         end
         PH_TAIL: begin
            if (b == ttfd_pkg::TAIL0_FIRST) begin
               phase_in = PH_TAIL0;
            end else if (b == ttfd_pkg::TAIL1_FIRST) begin
               phase_in = PH_TAIL1;
            end else begin
               phase_in = resync;
            end
         end
         PH_TAIL0: begin
            if (b == ttfd_pkg::TAIL0_LAST) begin
               emit     = 1'b1;
               phase_in = PH_HUNT;
            end else begin
               phase_in = resync;
            end
         end
         PH_TAIL1: begin
            kind = ttfd_pkg::KIND_TAIL1;
            if (b == ttfd_pkg::TAIL1_LAST) begin
               emit     = 1'b1;
               phase_in = PH_HUNT;
            end else begin
               phase_in = resync;
            end
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HUNT;
         distance_ff <= '0;
         length_ff   <= '0;
      end else if (advance && slot.valid) begin
         phase_ff    <= phase_in;
         distance_ff <= distance_in;
         length_ff   <= length_in;
      end
   end

   assign result.valid        = advance && slot.valid && emit;
   assign result.frame_kind   = kind;
   assign result.distance_raw = distance_ff;
   assign result.length_raw   = length_ff;

endmodule

`default_nettype wire

>>> rtl/ttfd_out_stage.sv
// ----------------------------------------------------------------------------
// Two-tail frame deframer output stage
// Result register; holds a frame result until the consumer takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ttfd_out_stage (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ttfd_pkg::result_type result,
   input  wire logic                 rsp_stall,
   output logic                      advance,
   output logic                      rsp_valid,
   output logic                      rsp_frame_kind,
   output logic [15:0]               rsp_distance_raw,
   output logic [15:0]               rsp_length_raw
);

   logic        valid_ff;
   logic        valid_in;
   logic        kind_ff;
   logic [15:0] distance_ff;
   logic [15:0] length_ff;

   // advance when the result register is empty or being drained
   assign advance  = !valid_ff || !rsp_stall;
   assign valid_in = result.valid || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (result.valid) begin
         kind_ff     <= result.frame_kind;
         distance_ff <= result.distance_raw;
         length_ff   <= result.length_raw;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_frame_kind   = kind_ff;
   assign rsp_distance_raw = distance_ff;
   assign rsp_length_raw   = length_ff;

endmodule

`default_nettype wire

>>> rtl/ttfd_checker.sv
// ----------------------------------------------------------------------------
// Two-tail frame deframer port checker
// Port-level properties of the deframer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "two_tail_frame_deframer_macros.svh"

module ttfd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic [7:0]  req_rx_byte,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_frame_kind,
   input wire logic [15:0] rsp_distance_raw,
   input wire logic [15:0] rsp_length_raw
);

   logic req_take;
   logic rsp_take;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;

   `TTFD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_frame_kind) && $stable(rsp_distance_raw) && $stable(rsp_length_raw), "stalled result changed")

   `TTFD_ASSERT_IMPL(a_rsp_from_tail, clock, reset, $rose(rsp_valid), $past(req_take, 2) && ($past(req_rx_byte, 2) == ttfd_pkg::TAIL0_LAST || $past(req_rx_byte, 2) == ttfd_pkg::TAIL1_LAST), "result without a tail byte")

   `TTFD_ASSERT_IMPL(a_rsp_kind, clock, reset, $rose(rsp_valid), rsp_frame_kind == ($past(req_rx_byte, 2) == ttfd_pkg::TAIL1_LAST), "frame kind does not match tail")

   `TTFD_ASSERT_NEXT(a_rsp_spacing, clock, reset, rsp_take, !rsp_valid, "results closer than one frame")

endmodule

bind two_tail_frame_deframer ttfd_checker u_ttfd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_rx_byte      (req_rx_byte),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_frame_kind   (rsp_frame_kind),
   .rsp_distance_raw (rsp_distance_raw),
   .rsp_length_raw   (rsp_length_raw)
);

`default_nettype wire
